// ===== sv/u2u8_pkg.sv =====
// Shared types and constants of the UTF-16 to UTF-8 character filter.
package u2u8_pkg;

  localparam logic [5:0]  HighSurPrefix = 6'b110110;
  localparam logic [5:0]  LowSurPrefix  = 6'b110111;
  localparam logic [20:0] SuppBase      = 21'h10000;
  localparam logic [20:0] CpBackspace   = 21'h08;
  localparam logic [20:0] CpSpace       = 21'h20;
  localparam logic [20:0] CpDelete      = 21'h7F;
  localparam logic [20:0] Lim1Byte      = 21'h80;
  localparam logic [20:0] Lim2Byte      = 21'h800;
  localparam logic [20:0] Lim3Byte      = 21'h10000;
  localparam logic [7:0]  Lead2         = 8'hC0;
  localparam logic [7:0]  Lead3         = 8'hE0;
  localparam logic [7:0]  Lead4         = 8'hF0;
  localparam logic [1:0]  ContMark      = 2'b10;

  typedef struct packed {
    logic [20:0]     cp;
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            bs;
    logic            emit;
  } u2u8_char_t;

endpackage

// ===== sv/utf16_to_utf8_char_filter_core.sv =====
// Top level of the UTF-16 to UTF-8 character filter: decode, byte serialiser, output register.
//
//   channel | signals                                                            | role
//   --------+--------------------------------------------------------------------+-----------
//   input   | in_valid, in_ready, code_unit                                      | code units
//   output  | out_valid, out_ready, utf8_byte, code_point, is_backspace, is_last | bytes
//
// A code unit is decoded in the cycle it is accepted; its 1 to 4 bytes then leave one per
// cycle while the output is not stalled, from the character register through the output
// register and the one-byte output port. Units that give no result send no byte.
// Reset clears the stored surrogate and all valid flags. An output stall holds the output
// register and the character register; input is taken again as soon as the last byte of
// the held character moves to the output register.
module utf16_to_utf8_char_filter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] code_unit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  utf8_byte,
  output logic [20:0] code_point,
  output logic        is_backspace,
  output logic        is_last
);
  import u2u8_pkg::*;

  u2u8_char_t dec;
  u2u8_char_t chr;
  logic       chr_valid;
  logic [1:0] idx;
  logic       pend_valid;
  logic [9:0] pend_bits;
  logic       pend_valid_next;
  logic [9:0] pend_bits_next;
  logic       take;
  logic       chr_done;
  logic       in_acc;

  u2u8_decode u_decode (
    .code_unit       (code_unit),
    .pend_valid      (pend_valid),
    .pend_bits       (pend_bits),
    .chr             (dec),
    .pend_valid_next (pend_valid_next),
    .pend_bits_next  (pend_bits_next)
  );

  assign take     = chr_valid && (!out_valid || out_ready);
  assign chr_done = take && (idx == chr.last_idx);
  assign in_ready = !chr_valid || chr_done;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      chr_valid  <= 1'b0;
      idx        <= 2'd0;
      out_valid  <= 1'b0;
    end else begin
      if (in_acc) begin
        pend_valid <= pend_valid_next;
      end
      if (take) begin
        idx <= chr_done ? 2'd0 : idx + 2'd1;
      end
      if (in_acc && dec.emit) begin
        chr_valid <= 1'b1;
      end else if (chr_done) begin
        chr_valid <= 1'b0;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_bits <= pend_bits_next;
    end
    if (in_acc && dec.emit) begin
      chr <= dec;
    end
    if (take) begin
      utf8_byte    <= chr.bytes[idx];
      code_point   <= chr.cp;
      is_backspace <= chr.bs;
      is_last      <= idx == chr.last_idx;
    end
  end

endmodule

// ===== sv/u2u8_decode.sv =====
// Surrogate pairing, control filtering and UTF-8 byte formation for one code unit.
module u2u8_decode (
  input  logic [15:0]       code_unit,
  input  logic              pend_valid,
  input  logic [9:0]        pend_bits,
  output u2u8_pkg::u2u8_char_t chr,
  output logic              pend_valid_next,
  output logic [9:0]        pend_bits_next
);
  import u2u8_pkg::*;

  logic        is_hi;
  logic        is_lo;
  logic [20:0] cp;
  logic        ctrl;
  logic        bs;

  always_comb begin
    is_hi = code_unit[15:10] == HighSurPrefix;
    is_lo = code_unit[15:10] == LowSurPrefix;
    pend_valid_next = is_hi;
    pend_bits_next  = code_unit[9:0];

    if (is_lo) begin
      cp = SuppBase + {1'b0, pend_bits, code_unit[9:0]};
    end else begin
      cp = {5'b0, code_unit};
    end

    bs   = !is_lo && (cp == CpBackspace);
    ctrl = (cp < CpSpace) || (cp == CpDelete);

    chr.cp    = cp;
    chr.bs    = bs;
    chr.emit  = !is_hi && (!is_lo || pend_valid) && (bs || !ctrl);
    chr.bytes = '0;

    if (bs) begin
      chr.last_idx = 2'd0;
    end else if (cp < Lim1Byte) begin
      chr.last_idx = 2'd0;
      chr.bytes[0] = cp[7:0];
    end else if (cp < Lim2Byte) begin
      chr.last_idx = 2'd1;
      chr.bytes[0] = Lead2 | {3'b0, cp[10:6]};
      chr.bytes[1] = {ContMark, cp[5:0]};
    end else if (cp < Lim3Byte) begin
      chr.last_idx = 2'd2;
      chr.bytes[0] = Lead3 | {4'b0, cp[15:12]};
      chr.bytes[1] = {ContMark, cp[11:6]};
      chr.bytes[2] = {ContMark, cp[5:0]};
    end else begin
      chr.last_idx = 2'd3;
      chr.bytes[0] = Lead4 | {5'b0, cp[20:18]};
      chr.bytes[1] = {ContMark, cp[17:12]};
      chr.bytes[2] = {ContMark, cp[11:6]};
      chr.bytes[3] = {ContMark, cp[5:0]};
    end
  end

endmodule

// ===== dv/utf8_stream_checker.sv =====
// Checker for the UTF-16 to UTF-8 character filter: transcodes accepted units, compares bytes, code points, flags.
module utf8_stream_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [15:0] code_unit,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  utf8_byte,
  input  logic [20:0] code_point,
  input  logic        is_backspace,
  input  logic        is_last,
  output int          err_count,
  output int          bytes_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import u2u8_pkg::*;

  typedef struct packed {
    logic [7:0]  octet;
    logic [20:0] cp;
    logic        bs;
    logic        last;
  } utf8_item_t;

  utf8_item_t  owed_q[$];
  logic [15:0] held_high;

  function automatic void owe(logic [7:0] octet, logic [20:0] cp, logic bs, logic last);
    utf8_item_t entry;
    entry = '{octet: octet, cp: cp, bs: bs, last: last};
    owed_q.insert(owed_q.size(), entry);
  endfunction

  function automatic void transcode_unit(logic [15:0] unit);
    logic [20:0] cp;
    if (unit[15:10] == HighSurPrefix) begin
      held_high = unit;
      return;
    end
    if (unit[15:10] == LowSurPrefix) begin
      if (held_high[15:10] != HighSurPrefix) begin
        held_high = '0;
        return;
      end
      cp = SuppBase + {1'b0, held_high[9:0], unit[9:0]};
    end else begin
      cp = {5'b0, unit};
    end
    held_high = '0;

    if (cp == CpBackspace) begin
      owe(8'h00, cp, 1'b1, 1'b1);
      return;
    end
    // drop control characters
    if (cp < CpSpace || cp == CpDelete) return;

    if (cp < Lim1Byte) begin
      owe(cp[7:0], cp, 1'b0, 1'b1);
    end else if (cp < Lim2Byte) begin
      owe({3'b110, cp[10:6]}, cp, 1'b0, 1'b0);
      owe({2'b10, cp[5:0]}, cp, 1'b0, 1'b1);
    end else if (cp < Lim3Byte) begin
      owe({4'b1110, cp[15:12]}, cp, 1'b0, 1'b0);
      owe({2'b10, cp[11:6]}, cp, 1'b0, 1'b0);
      owe({2'b10, cp[5:0]}, cp, 1'b0, 1'b1);
    end else begin
      owe({5'b11110, cp[20:18]}, cp, 1'b0, 1'b0);
      owe({2'b10, cp[17:12]}, cp, 1'b0, 1'b0);
      owe({2'b10, cp[11:6]}, cp, 1'b0, 1'b0);
      owe({2'b10, cp[5:0]}, cp, 1'b0, 1'b1);
    end
  endfunction

  always @(posedge clk) begin
    utf8_item_t want;
    utf8_item_t got;
    if (rst) begin
      held_high = '0;
      owed_q.delete();
      err_count = 0;
    end else begin
      if (in_valid && in_ready) transcode_unit(code_unit);
      if (out_valid && out_ready) begin
        got = '{octet: utf8_byte, cp: code_point, bs: is_backspace, last: is_last};
        if (owed_q.size() == 0) begin
          err_count++;
          $display("%0t: expected no transaction, got byte %h cp %h bs %b last %b",
                   $time, got.octet, got.cp, got.bs, got.last);
        end else begin
          want = owed_q.pop_front();
          if (got !== want) begin
            err_count++;
            $display("%0t: expected byte %h cp %h bs %b last %b, got byte %h cp %h bs %b last %b",
                     $time, want.octet, want.cp, want.bs, want.last,
                     got.octet, got.cp, got.bs, got.last);
          end
        end
      end
    end
    bytes_owed = owed_q.size();
  end

endmodule

// ===== dv/tb_utf16_to_utf8_char_filter_core.sv =====
// Testbench top for the UTF-16 to UTF-8 character filter: clock, reset, stimulus and verdict.
module tb_utf16_to_utf8_char_filter_core;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] code_unit = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  utf8_byte;
  logic [20:0] code_point;
  logic        is_backspace;
  logic        is_last;

  int err_count;
  int bytes_owed;
  int units_sent = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;

  localparam logic [15:0] DirectedUnits[24] = '{
    16'h0000, 16'h0008, 16'h001F, 16'h0020, 16'h007E, 16'h007F, 16'h0080, 16'h009F,
    16'h07FF, 16'h0800, 16'hFFFE, 16'hFFFF, 16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF,
    16'hDC00, 16'hD800, 16'hDBFF, 16'hDC00, 16'hD812, 16'h0041, 16'hD800, 16'h0008
  };

  utf16_to_utf8_char_filter_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .code_unit    (code_unit),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .utf8_byte    (utf8_byte),
    .code_point   (code_point),
    .is_backspace (is_backspace),
    .is_last      (is_last)
  );

  utf8_stream_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .code_unit    (code_unit),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .utf8_byte    (utf8_byte),
    .code_point   (code_point),
    .is_backspace (is_backspace),
    .is_last      (is_last),
    .err_count    (err_count),
    .bytes_owed   (bytes_owed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_unit(input logic [15:0] unit);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    code_unit <= unit;
    do @(posedge clk); while (!in_ready);
    units_sent++;
    @(negedge clk);
  endtask

  task automatic send_random();
    int          pick;
    logic [15:0] unit;
    pick = $urandom_range(99);
    if (pick < 20) begin
      send_unit(16'($urandom_range(16'h7E, 16'h20)));
    end else if (pick < 35) begin
      send_unit(16'($urandom_range(16'h7FF, 16'h80)));
    end else if (pick < 55) begin
      do unit = 16'($urandom_range(16'hFFFF, 16'h800)); while (unit[15:11] == 5'b11011);
      send_unit(unit);
    end else if (pick < 82) begin
      send_unit(16'hD800 | 16'($urandom_range(1023)));
      send_unit(16'hDC00 | 16'($urandom_range(1023)));
    end else begin
      case ($urandom_range(4))
        0: send_unit(16'($urandom));
        1: send_unit(16'hDC00 | 16'($urandom_range(1023)));
        2: begin
          send_unit(16'hD800 | 16'($urandom_range(1023)));
          send_unit(16'($urandom_range(16'h7E, 16'h00)));
        end
        3: send_unit(($urandom_range(3) == 0) ? 16'h7F : 16'($urandom_range(31)));
        default: begin
          send_unit(16'hD800 | 16'($urandom_range(1023)));
          send_unit(16'hD800 | 16'($urandom_range(1023)));
          send_unit(16'hDC00 | 16'($urandom_range(1023)));
        end
      endcase
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (DirectedUnits[i]) send_unit(DirectedUnits[i]);
    send_unit(16'hDFFF);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin sender_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      while (units_sent < 25 + 100 * (phase + 1)) send_random();
    end

    in_valid <= 1'b0;
    while (bytes_owed != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
